/* hdl/bpdq_pkg.sv */
// Shared constants, codes and types of the bounded packet deque.
package bpdq_pkg;

  localparam int DEPTH      = 256;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int MAXP_W     = 9;
  localparam int CMP_W      = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;
  localparam int KIND_W     = 2;
  localparam int CFG_DATA_W = 9;
  localparam int OCC_W      = 9;

  localparam logic [PTR_W-1:0]  PTR_LAST      = PTR_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0]  DEPTH_CMP     = CMP_W'(DEPTH);
  localparam logic [MAXP_W-1:0] MAXP_RESET    = MAXP_W'(256);
  localparam logic [KIND_W-1:0] KIND_RESET    = KIND_W'(2);

  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP        = 3'd2,
    OP_FLUSH      = 3'd3,
    OP_READ_STATS = 3'd4,
    OP_RESET_NEW  = 3'd5,
    OP_PEEK       = 3'd6
  } op_t;

  typedef enum logic [0:0] {
    CFG_MAX_PACKETS  = 1'b0,
    CFG_REQUEST_KIND = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0] tick;
    logic [15:0] length;
    logic [15:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [PTR_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    logic             ok;
    logic [15:0]      out_handle;
    logic [15:0]      out_length;
    logic [31:0]      out_tick;
    logic [OCC_W-1:0] occupancy;
    logic [31:0]      new_pkts;
    logic [31:0]      new_bytes;
    logic [31:0]      current_bytes;
    logic [31:0]      in_pkts;
    logic [31:0]      out_pkts;
    logic [31:0]      in_bytes;
    logic [31:0]      out_bytes;
  } out_item_t;

endpackage

/* hdl/bpdq_in_if.sv */
// Input channel of the packet deque: valid/ready handshake with one operation.
interface bpdq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] elem_handle;
  logic [15:0] elem_length;
  logic [31:0] elem_tick;
  logic [1:0]  kind_query;

  modport source (output valid, output op, output elem_handle, output elem_length,
                  output elem_tick, output kind_query, input ready);
  modport sink (input valid, input op, input elem_handle, input elem_length,
                input elem_tick, input kind_query, output ready);
endinterface

/* hdl/bpdq_out_if.sv */
// Result channel of the packet deque: valid/ready handshake with one result.
interface bpdq_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] out_handle;
  logic [15:0] out_length;
  logic [31:0] out_tick;
  logic [8:0]  occupancy;
  logic [31:0] new_pkts;
  logic [31:0] new_bytes;
  logic [31:0] current_bytes;
  logic [31:0] in_pkts;
  logic [31:0] out_pkts;
  logic [31:0] in_bytes;
  logic [31:0] out_bytes;

  modport source (output valid, output ok, output out_handle, output out_length,
                  output out_tick, output occupancy, output new_pkts, output new_bytes,
                  output current_bytes, output in_pkts, output out_pkts, output in_bytes,
                  output out_bytes, input ready);
  modport sink (input valid, input ok, input out_handle, input out_length,
                input out_tick, input occupancy, input new_pkts, input new_bytes,
                input current_bytes, input in_pkts, input out_pkts, input in_bytes,
                input out_bytes, output ready);
endinterface

/* hdl/bounded_packet_deque_with_stats_top.sv */
// Top level of the bounded packet deque: entry store, controller and result register.
//
// Usage: operations arrive on in_ch (valid/ready); each accepted operation yields
// exactly one result on out_ch (valid/ready), in order. Push and push front
// store a descriptor, pop returns the head descriptor, peek returns the head tick,
// and flush, read stats and reset new act on the counters; flush also empties the queue.
// Configuration goes through cfg_we/cfg_index/cfg_data: index CFG_MAX_PACKETS sets
// the capacity limit (reset 256), CFG_REQUEST_KIND the credit request kind (reset 2).
// Write configuration only while no operation is outstanding.
// A result is on out_ch in the cycle after its transfer; a pop or peek on a
// non-empty queue first reads the head entry through the store's registered read
// port (state ST_READ) before its result is registered. One operation is taken per
// cycle while out_ch takes results, none while such a head read is in progress.
// Reset (rst_n low, synchronous) empties the queue and clears all counters; the
// store itself is not cleared, as only written entries are ever read.
// A stalled receiver holds the result in the output register; a new operation is
// taken in the cycle that the waiting result transfers, and not before.
module bounded_packet_deque_with_stats_top (
  input  logic                            clk,
  input  logic                            rst_n,
  bpdq_in_if.sink                         in_ch,
  bpdq_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  bpdq_pkg::cfg_reg_t              cfg_index,
  input  logic [bpdq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bpdq_pkg::*;

  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_valid;
  out_item_t          res;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r;
  logic               out_free;

  bpdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  bpdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_free  (out_free),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_r.ok;
  assign out_ch.out_handle    = out_r.out_handle;
  assign out_ch.out_length    = out_r.out_length;
  assign out_ch.out_tick      = out_r.out_tick;
  assign out_ch.occupancy     = out_r.occupancy;
  assign out_ch.new_pkts      = out_r.new_pkts;
  assign out_ch.new_bytes     = out_r.new_bytes;
  assign out_ch.current_bytes = out_r.current_bytes;
  assign out_ch.in_pkts       = out_r.in_pkts;
  assign out_ch.out_pkts      = out_r.out_pkts;
  assign out_ch.in_bytes      = out_r.in_bytes;
  assign out_ch.out_bytes     = out_r.out_bytes;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result produced while the output register holds an untaken one");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

  a_taken_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && !res_valid |=> !out_valid_r)
    else $error("taken result presented again");
`endif

endmodule

/* hdl/bpdq_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
module bpdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bpdq_ctrl.sv */
// Deque controller: pointers, counters, configuration and the head read sequence.
module bpdq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  bpdq_in_if.sink                         in_ch,
  input  logic                            out_free,
  input  logic                            cfg_we,
  input  bpdq_pkg::cfg_reg_t              cfg_index,
  input  logic [bpdq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bpdq_pkg::ENTRY_W-1:0]    ram_rdata,
  output bpdq_pkg::ram_req_t              ram_req,
  output logic                            res_valid,
  output bpdq_pkg::out_item_t             res
);
  import bpdq_pkg::*;

  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       new_pkt_r, new_pkt_nxt;
  logic [31:0]       new_byte_r, new_byte_nxt;
  logic [31:0]       held_bytes_r, held_bytes_nxt;
  logic [31:0]       in_pkt_r, in_pkt_nxt;
  logic [31:0]       out_pkt_r, out_pkt_nxt;
  logic [31:0]       in_byte_r, in_byte_nxt;
  logic [31:0]       out_byte_r, out_byte_nxt;
  logic [MAXP_W-1:0] max_packets_r;
  logic [KIND_W-1:0] request_kind_r;

  logic              accept;
  op_t               in_op;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [CMP_W-1:0]  cap;
  logic              has_room;
  logic              nonempty;
  logic [31:0]       push_len;
  logic [31:0]       pop_len;
  logic [PTR_W-1:0]  head_dec;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;

  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_op       = op_t'(in_ch.op);
  assign rd_entry    = entry_t'(ram_rdata);
  assign wr_entry    = '{tick: in_ch.elem_tick, length: in_ch.elem_length,
                         handle: in_ch.elem_handle};

  // A limit above the store depth acts as the depth.
  assign cap      = (CMP_W'(max_packets_r) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(max_packets_r);
  assign has_room = CMP_W'(count_r) < cap;
  assign nonempty = count_r != '0;
  assign push_len = 32'(in_ch.elem_length);
  assign pop_len  = 32'(rd_entry.length);
  assign head_dec = (head_r == '0) ? PTR_LAST : head_r - PTR_W'(1);
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    new_pkt_nxt    = new_pkt_r;
    new_byte_nxt   = new_byte_r;
    held_bytes_nxt = held_bytes_r;
    in_pkt_nxt     = in_pkt_r;
    out_pkt_nxt    = out_pkt_r;
    in_byte_nxt    = in_byte_r;
    out_byte_nxt   = out_byte_r;
    ram_req        = '0;
    ram_req.wdata  = wr_entry;
    ram_req.raddr  = head_r;
    res_valid      = 1'b0;
    res            = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          case (in_op)
            OP_PUSH: begin
              if (has_room) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = tail_r;
                tail_nxt      = tail_inc;
                count_nxt     = count_r + CNT_W'(1);
                new_pkt_nxt   = new_pkt_r + 32'd1;
                in_pkt_nxt    = in_pkt_r + 32'd1;
                new_byte_nxt  = new_byte_r + push_len;
                held_bytes_nxt = held_bytes_r + push_len;
                in_byte_nxt   = in_byte_r + push_len;
                res.ok        = 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (has_room) begin
                ram_req.we     = 1'b1;
                ram_req.waddr  = head_dec;
                head_nxt       = head_dec;
                count_nxt      = count_r + CNT_W'(1);
                held_bytes_nxt = held_bytes_r + push_len;
                out_byte_nxt   = out_byte_r - push_len;
                res.ok         = 1'b1;
              end
            end
            OP_POP, OP_PEEK: begin
              // A non-empty queue fetches the head entry; the result follows next cycle.
              if (nonempty) begin
                ram_req.re = 1'b1;
                state_nxt  = ST_READ;
                res_valid  = 1'b0;
              end
            end
            OP_FLUSH: begin
              head_nxt       = '0;
              tail_nxt       = '0;
              count_nxt      = '0;
              new_pkt_nxt    = '0;
              new_byte_nxt   = '0;
              held_bytes_nxt = '0;
              in_pkt_nxt     = '0;
              out_pkt_nxt    = '0;
              in_byte_nxt    = '0;
              out_byte_nxt   = '0;
            end
            OP_READ_STATS: begin
              res.in_pkts   = in_pkt_r;
              res.out_pkts  = out_pkt_r;
              res.in_bytes  = in_byte_r;
              res.out_bytes = out_byte_r;
              in_pkt_nxt    = '0;
              out_pkt_nxt   = '0;
              in_byte_nxt   = '0;
              out_byte_nxt  = '0;
            end
            OP_RESET_NEW: begin
              if (in_ch.kind_query == request_kind_r) begin
                new_pkt_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_valid    = 1'b1;
        state_nxt    = ST_IDLE;
        res.out_tick = rd_entry.tick;
        if (op_r == OP_POP) begin
          head_nxt       = head_inc;
          count_nxt      = count_r - CNT_W'(1);
          out_pkt_nxt    = out_pkt_r + 32'd1;
          held_bytes_nxt = held_bytes_r - pop_len;
          out_byte_nxt   = out_byte_r + pop_len;
          res.ok         = 1'b1;
          res.out_handle = rd_entry.handle;
          res.out_length = rd_entry.length;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.occupancy     = OCC_W'(count_nxt);
    res.new_pkts      = new_pkt_nxt;
    res.new_bytes     = new_byte_nxt;
    res.current_bytes = held_bytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      new_pkt_r    <= '0;
      new_byte_r   <= '0;
      held_bytes_r <= '0;
      in_pkt_r     <= '0;
      out_pkt_r    <= '0;
      in_byte_r    <= '0;
      out_byte_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      new_pkt_r    <= new_pkt_nxt;
      new_byte_r   <= new_byte_nxt;
      held_bytes_r <= held_bytes_nxt;
      in_pkt_r     <= in_pkt_nxt;
      out_pkt_r    <= out_pkt_nxt;
      in_byte_r    <= in_byte_nxt;
      out_byte_r   <= out_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_packets_r  <= MAXP_RESET;
      request_kind_r <= KIND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PACKETS:  max_packets_r  <= cfg_data;
        CFG_REQUEST_KIND: request_kind_r <= cfg_data[KIND_W-1:0];
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= DEPTH_CMP)
    else $error("occupancy exceeds store depth");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE)
    else $error("head read lasted more than one cycle");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> res_valid && !ram_req.we)
    else $error("head read without a result or with a store write");

  a_fetch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.re |-> nonempty && accept && (in_op == OP_POP || in_op == OP_PEEK))
    else $error("head fetch without a pop or peek on a non-empty queue");
`endif

endmodule

/* test/bpdq_result_checker.sv */
// Checker for the packet deque: tracks its state, predicts each result and compares it.
module bpdq_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  bpdq_in_if                              in_mon,
  bpdq_out_if                             out_mon,
  input  logic                            cfg_we,
  input  bpdq_pkg::cfg_reg_t              cfg_index,
  input  logic [bpdq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              error_total,
  output int                              results_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import bpdq_pkg::*;

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  head_idx;
  logic [PTR_W-1:0]  tail_idx;
  int                held_pkts;
  logic [31:0]       new_pkt_cnt;
  logic [31:0]       new_byte_cnt;
  logic [31:0]       held_byte_cnt;
  logic [31:0]       in_pkt_cnt;
  logic [31:0]       out_pkt_cnt;
  logic [31:0]       in_byte_cnt;
  logic [31:0]       out_byte_cnt;
  logic [MAXP_W-1:0] cap_limit;
  logic [KIND_W-1:0] own_kind;
  out_item_t         expected_results [$];
  out_item_t         oldest;
  out_item_t         predicted;

  function automatic void clear_traffic();
    in_pkt_cnt   = '0;
    out_pkt_cnt  = '0;
    in_byte_cnt  = '0;
    out_byte_cnt = '0;
  endfunction

  function automatic void empty_deque();
    head_idx      = '0;
    tail_idx      = '0;
    held_pkts     = 0;
    new_pkt_cnt   = '0;
    new_byte_cnt  = '0;
    held_byte_cnt = '0;
    clear_traffic();
  endfunction

  // Applies one operation to the tracked deque and returns the result it must produce.
  function automatic out_item_t predict_result(input logic [2:0] code,
                                               input logic [15:0] elem_handle,
                                               input logic [15:0] elem_length,
                                               input logic [31:0] elem_tick,
                                               input logic [1:0] kind);
    out_item_t r;
    entry_t    e;
    int        room;
    r = '0;
    // A limit above the store depth behaves as the depth itself.
    room = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
    case (code)
      OP_PUSH: begin
        if (held_pkts < room) begin
          slots[tail_idx] = '{tick: elem_tick, length: elem_length, handle: elem_handle};
          tail_idx++;
          held_pkts++;
          new_pkt_cnt++;
          in_pkt_cnt++;
          new_byte_cnt  += 32'(elem_length);
          held_byte_cnt += 32'(elem_length);
          in_byte_cnt   += 32'(elem_length);
          r.ok = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        // A re-queued fragment takes its bytes back out of the outgoing count.
        if (held_pkts < room) begin
          head_idx--;
          slots[head_idx] = '{tick: elem_tick, length: elem_length, handle: elem_handle};
          held_pkts++;
          held_byte_cnt += 32'(elem_length);
          out_byte_cnt  -= 32'(elem_length);
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (held_pkts > 0) begin
          e = slots[head_idx];
          head_idx++;
          held_pkts--;
          out_pkt_cnt++;
          held_byte_cnt -= 32'(e.length);
          out_byte_cnt  += 32'(e.length);
          r.ok         = 1'b1;
          r.out_handle = e.handle;
          r.out_length = e.length;
          r.out_tick   = e.tick;
        end
      end
      OP_FLUSH: begin
        empty_deque();
      end
      OP_READ_STATS: begin
        r.in_pkts   = in_pkt_cnt;
        r.out_pkts  = out_pkt_cnt;
        r.in_bytes  = in_byte_cnt;
        r.out_bytes = out_byte_cnt;
        clear_traffic();
      end
      OP_RESET_NEW: begin
        if (kind == own_kind) new_pkt_cnt = '0;
      end
      OP_PEEK: begin
        if (held_pkts > 0) r.out_tick = slots[head_idx].tick;
      end
      default: begin
      end
    endcase
    r.occupancy     = OCC_W'(held_pkts);
    r.new_pkts      = new_pkt_cnt;
    r.new_bytes     = new_byte_cnt;
    r.current_bytes = held_byte_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      error_total++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_deque();
      cap_limit   = MAXP_RESET;
      own_kind    = KIND_RESET;
      error_total = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_PACKETS:  cap_limit = cfg_data[MAXP_W-1:0];
          CFG_REQUEST_KIND: own_kind  = cfg_data[KIND_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          error_total++;
          $display("%0t: result transfer with no operation outstanding", $time);
        end else begin
          oldest = expected_results.pop_front();
          check_field("ok", 32'(oldest.ok), 32'(out_mon.ok));
          check_field("out_handle", 32'(oldest.out_handle), 32'(out_mon.out_handle));
          check_field("out_length", 32'(oldest.out_length), 32'(out_mon.out_length));
          check_field("out_tick", oldest.out_tick, out_mon.out_tick);
          check_field("occupancy", 32'(oldest.occupancy), 32'(out_mon.occupancy));
          check_field("new_pkts", oldest.new_pkts, out_mon.new_pkts);
          check_field("new_bytes", oldest.new_bytes, out_mon.new_bytes);
          check_field("current_bytes", oldest.current_bytes, out_mon.current_bytes);
          check_field("in_pkts", oldest.in_pkts, out_mon.in_pkts);
          check_field("out_pkts", oldest.out_pkts, out_mon.out_pkts);
          check_field("in_bytes", oldest.in_bytes, out_mon.in_bytes);
          check_field("out_bytes", oldest.out_bytes, out_mon.out_bytes);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted = predict_result(in_mon.op, in_mon.elem_handle, in_mon.elem_length,
                                   in_mon.elem_tick, in_mon.kind_query);
        expected_results.insert(expected_results.size(), predicted);
      end
    end
    results_waiting = expected_results.size();
  end

endmodule

/* test/tb_bounded_packet_deque_with_stats_top.sv */
// Clock, reset, stimulus and verdict for the bounded packet deque.
module tb_bounded_packet_deque_with_stats_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpdq_pkg::*;

  localparam logic [2:0] OP_UNUSED     = 3'd7;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         PHASES        = 6;
  localparam int         PHASE_ITEMS   = 130;
  localparam int         FILL_ITEMS    = DEPTH + 2;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    error_total;
  int                    results_waiting;
  int                    send_gap_pct = 8;
  int                    recv_gap_pct = 82;
  int                    hold_requests = 0;
  int                    hold_served = 0;
  int                    hold_left = 0;
  int                    idle_cycles = 0;

  logic [MAXP_W-1:0] phase_cap  [PHASES] = '{9'd3, 9'd256, 9'd0, 9'd511, 9'd1, 9'd40};
  logic [KIND_W-1:0] phase_kind [PHASES] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1};

  bpdq_in_if  in_ch ();
  bpdq_out_if out_ch ();

  bounded_packet_deque_with_stats_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bpdq_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_total     (error_total),
    .results_waiting (results_waiting)
  );

  always #4 clk = ~clk;

  // Result side: random back-pressure, plus one long hold-off when the stimulus asks.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(input logic [2:0] code, input logic [15:0] elem_handle,
                         input logic [15:0] elem_length, input logic [31:0] elem_tick,
                         input logic [1:0] kind);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= code;
    in_ch.elem_handle <= elem_handle;
    in_ch.elem_length <= elem_length;
    in_ch.elem_tick   <= elem_tick;
    in_ch.kind_query  <= kind;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_op();
    int          roll;
    logic [2:0]  code;
    logic [15:0] len;
    logic [31:0] tick;
    roll = $urandom_range(99);
    if (roll < 36)      code = OP_PUSH;
    else if (roll < 48) code = OP_PUSH_FRONT;
    else if (roll < 80) code = OP_POP;
    else if (roll < 87) code = OP_PEEK;
    else if (roll < 92) code = OP_READ_STATS;
    else if (roll < 96) code = OP_RESET_NEW;
    else if (roll < 98) code = OP_FLUSH;
    else                code = OP_UNUSED;
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = '1;
      default: len = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0:       tick = '0;
      1:       tick = '1;
      default: tick = $urandom;
    endcase
    send_op(code, 16'($urandom), len, tick, 2'($urandom_range(3)));
  endtask

  // Waits until every result has been taken and the block has gone quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [MAXP_W-1:0] cap, input logic [KIND_W-1:0] kind);
    drain();
    write_reg(CFG_MAX_PACKETS, cap);
    write_reg(CFG_REQUEST_KIND, CFG_DATA_W'(kind));
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MAX_PACKETS;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_PUSH;
    in_ch.elem_handle = '0;
    in_ch.elem_length = '0;
    in_ch.elem_tick   = '0;
    in_ch.kind_query  = '0;
    out_ch.ready      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: empty queue first, then field extremes.
    send_op(OP_POP, '0, '0, '0, '0);
    send_op(OP_PEEK, '0, '0, '0, '0);
    send_op(OP_READ_STATS, '0, '0, '0, '0);
    send_op(OP_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send_op(OP_PUSH, '0, '0, '0, '0);
    // The fragment drives the outgoing byte count below zero, so it wraps.
    send_op(OP_PUSH_FRONT, 16'h1234, 16'd100, 32'd5, '0);
    send_op(OP_PEEK, '0, '0, '0, '0);
    send_op(OP_RESET_NEW, '0, '0, '0, 2'd1);
    send_op(OP_RESET_NEW, '0, '0, '0, 2'd2);
    send_op(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send_op(OP_READ_STATS, '0, '0, '0, '0);
    repeat (4) send_op(OP_POP, '0, '0, '0, '0);
    send_op(OP_PUSH, 16'hABCD, 16'd7, 32'd9, '0);
    send_op(OP_FLUSH, '0, '0, '0, '0);
    send_op(OP_READ_STATS, '0, '0, '0, '0);

    // A two-entry limit: the third push and the fragment are both refused.
    apply_setting(9'd2, 2'd0);
    send_op(OP_PUSH, 16'd1, 16'd10, 32'd100, '0);
    send_op(OP_PUSH, 16'd2, 16'd20, 32'd200, '0);
    send_op(OP_PUSH, 16'd3, 16'd30, 32'd300, '0);
    send_op(OP_PUSH_FRONT, 16'd4, 16'd40, 32'd400, '0);
    send_op(OP_RESET_NEW, '0, '0, '0, 2'd0);
    send_op(OP_POP, '0, '0, '0, '0);
    send_op(OP_POP, '0, '0, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(phase_cap[p], phase_kind[p]);
      if (p == 2) begin
        send_gap_pct = 82;
        recv_gap_pct = 8;
      end
      if (p == 4) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      repeat (PHASE_ITEMS) send_random_op();
    end

    // Fill the whole store, starting under a long hold-off on the result side, then empty it again.
    apply_setting(MAXP_RESET, KIND_RESET);
    hold_requests++;
    repeat (FILL_ITEMS) send_op(OP_PUSH, 16'($urandom), 16'($urandom), $urandom, '0);
    send_op(OP_PUSH_FRONT, 16'($urandom), 16'($urandom), $urandom, '0);
    send_op(OP_PEEK, '0, '0, '0, '0);
    repeat (FILL_ITEMS) send_op(OP_POP, '0, '0, '0, '0);
    send_op(OP_READ_STATS, '0, '0, '0, '0);

    drain();
    if (error_total == 0 && results_waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bpdq_pkg.sv
hdl/bpdq_in_if.sv
hdl/bpdq_out_if.sv
hdl/bpdq_ram.sv
hdl/bpdq_ctrl.sv
hdl/bounded_packet_deque_with_stats_top.sv
test/bpdq_result_checker.sv
test/tb_bounded_packet_deque_with_stats_top.sv
